// File: rtl/scm_pkg.sv
// Shared types and constants for the substring first-match search block.
package scm_pkg;

    localparam int CH_W  = 8;
    localparam int IDX_W = 16;

    typedef struct packed {
        logic            mode;
        logic [CH_W-1:0] ch;
        logic            last;
    } t_in;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
        logic             overflow;
    } t_out;

    typedef enum logic [1:0] {
        CMD_PAT_FIRST,
        CMD_PAT_NEXT,
        CMD_TEXT,
        CMD_TEXT_LAST
    } t_cmd;

    typedef struct packed {
        t_cmd            cmd;
        logic [CH_W-1:0] ch;
    } t_qitem;

endpackage

// File: rtl/substring_first_match.sv
// Top level: first-occurrence substring search over a character stream.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one character per
// transaction. mode 0 loads pattern characters, last closing the pattern; a
// pattern character after a closed pattern starts a new load. mode 1 sends
// text; the text character with last set produces exactly one result.
// Output channel (o_out_valid / i_out_ready / o_out_data): found, the start
// index of the earliest match (0 when not found) and overflow.
// Throughput: one character per cycle, by a parallel compare of the character
// against all PATTERN_MAX stored pattern bytes, unless a last text character
// waits on a busy result register. The last text character of a search passes
// the input register and a queue entry before the engine writes its result register.
// Reset clears all control state; the pattern store needs no clearing pass.
// When the receiver stalls, the result register holds; the engine keeps
// consuming characters until it meets the next last text character, then the
// queue and input register fill and o_in_ready drops.
module substring_first_match #(
    parameter int PATTERN_MAX   = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  scm_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output scm_pkg::t_out o_out_data
);

    logic            push_valid;
    logic            push_ready;
    scm_pkg::t_qitem push_item;
    logic            pop_valid;
    logic            pop_ready;
    scm_pkg::t_qitem pop_item;

    scm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    scm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    scm_back #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (pop_valid),
        .o_ready     (pop_ready),
        .i_item      (pop_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_not_found_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.found) |-> (o_out_data.match_index == '0))
        else $error("match_index nonzero on a not-found result");

    a_last_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_valid && pop_ready && (pop_item.cmd == scm_pkg::CMD_TEXT_LAST))
            |-> (!o_out_valid || i_out_ready))
        else $error("final text char consumed while result register busy");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid)
            |-> $past(pop_valid && pop_ready && (pop_item.cmd == scm_pkg::CMD_TEXT_LAST)))
        else $error("result produced without a final text char");

endmodule

// File: rtl/scm_front.sv
// Input stage: accepts characters and classifies them into search commands.
module scm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  scm_pkg::t_in    i_in_data,
    output logic            o_push_valid,
    input  logic            i_push_ready,
    output scm_pkg::t_qitem o_push_item
);

    logic            r_valid;
    logic            n_valid;
    scm_pkg::t_qitem r_item;
    scm_pkg::t_qitem n_item;
    logic            r_pat_done;
    logic            n_pat_done;
    logic            accept;

    assign o_in_ready   = !r_valid || i_push_ready;
    assign accept       = i_in_valid && o_in_ready;
    assign o_push_valid = r_valid;
    assign o_push_item  = r_item;

    always_comb begin
        n_valid    = r_valid;
        n_item     = r_item;
        n_pat_done = r_pat_done;
        if (r_valid && i_push_ready) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid   = 1'b1;
            n_item.ch = i_in_data.ch;
            if (i_in_data.mode) begin
                n_item.cmd = i_in_data.last ? scm_pkg::CMD_TEXT_LAST : scm_pkg::CMD_TEXT;
                n_pat_done = 1'b1;
            end else begin
                // a pattern char after a closed pattern restarts the load
                n_item.cmd = r_pat_done ? scm_pkg::CMD_PAT_FIRST : scm_pkg::CMD_PAT_NEXT;
                n_pat_done = i_in_data.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pat_done <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_pat_done <= n_pat_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

// File: rtl/scm_queue.sv
// Two-entry command queue between the classifier and the match engine.
module scm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  scm_pkg::t_qitem i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output scm_pkg::t_qitem o_pop_item
);

    scm_pkg::t_qitem r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

// File: rtl/scm_back.sv
// Match engine: pattern store, shifted match vector and result register.
module scm_back #(
    parameter int PATTERN_MAX   = 64,
    parameter int POSITION_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  scm_pkg::t_qitem i_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output scm_pkg::t_out   o_out_data
);

    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int PB = POSITION_BITS;
    localparam int SW = PB + LW;
    localparam int XW = PB + scm_pkg::IDX_W;

    logic [scm_pkg::CH_W-1:0] r_pat [PATTERN_MAX];
    logic [LW-1:0]            r_len,       n_len;
    logic                     r_too_long,  n_too_long;
    logic [PATTERN_MAX-1:0]   r_partial,   n_partial;
    logic [PB-1:0]            r_pos,       n_pos;
    logic                     r_txt_ovf,   n_txt_ovf;
    logic                     r_seen,      n_seen;
    logic [PB-1:0]            r_start,     n_start;
    logic                     r_out_valid, n_out_valid;
    scm_pkg::t_out            r_out,       n_out;

    logic                   pop;
    logic                   pat_we;
    logic [IW-1:0]          pat_addr;
    logic [PATTERN_MAX:0]   shifted;
    logic [PATTERN_MAX-1:0] eq_vec;
    logic [PATTERN_MAX-1:0] nxt_partial;
    logic [PATTERN_MAX-1:0] top_vec;
    logic                   hit;
    logic                   sat;
    logic [SW-1:0]          start_sum;
    logic [XW-1:0]          start_ext;

    assign o_ready     = (i_item.cmd != scm_pkg::CMD_TEXT_LAST) || !r_out_valid || i_out_ready;
    assign pop         = i_valid && o_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // parallel compare against every stored pattern position
    assign shifted = {r_partial, 1'b1};
    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            eq_vec[i]      = (r_pat[i] == i_item.ch) && (LW'(i) < r_len);
            nxt_partial[i] = shifted[i] && eq_vec[i];
            top_vec[i]     = (LW'(i + 1) == r_len);
        end
    end

    assign hit       = (|(nxt_partial & top_vec)) && !r_too_long && !r_seen;
    assign sat       = (r_pos == {PB{1'b1}});
    assign start_sum = {{LW{1'b0}}, r_pos} + SW'(1) - {{PB{1'b0}}, r_len};

    always_comb begin
        n_len       = r_len;
        n_too_long  = r_too_long;
        n_partial   = r_partial;
        n_pos       = r_pos;
        n_txt_ovf   = r_txt_ovf;
        n_seen      = r_seen;
        n_start     = r_start;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        pat_we      = 1'b0;
        pat_addr    = r_len[IW-1:0];
        start_ext   = '0;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (pop) begin
            unique case (i_item.cmd)
                scm_pkg::CMD_PAT_FIRST: begin
                    pat_we     = 1'b1;
                    pat_addr   = '0;
                    n_len      = LW'(1);
                    n_too_long = 1'b0;
                end
                scm_pkg::CMD_PAT_NEXT: begin
                    if (r_len < LW'(PATTERN_MAX)) begin
                        pat_we = 1'b1;
                        n_len  = r_len + LW'(1);
                    end else begin
                        n_too_long = 1'b1;
                    end
                end
                scm_pkg::CMD_TEXT, scm_pkg::CMD_TEXT_LAST: begin
                    if (sat) begin
                        n_txt_ovf = 1'b1;
                    end else begin
                        n_partial = nxt_partial;
                        n_pos     = r_pos + PB'(1);
                        if (hit) begin
                            n_seen  = 1'b1;
                            n_start = start_sum[PB-1:0];
                        end
                    end
                end
            endcase
            if (i_item.cmd == scm_pkg::CMD_TEXT_LAST) begin
                start_ext         = {{scm_pkg::IDX_W{1'b0}}, n_start};
                n_out_valid       = 1'b1;
                n_out.found       = n_seen && !r_too_long && (r_len != '0);
                n_out.match_index = n_out.found ? start_ext[scm_pkg::IDX_W-1:0] : '0;
                n_out.overflow    = r_too_long || n_txt_ovf;
            end
            // every pattern char and every finished text drops the text state
            if (i_item.cmd != scm_pkg::CMD_TEXT) begin
                n_partial = '0;
                n_pos     = '0;
                n_txt_ovf = 1'b0;
                n_seen    = 1'b0;
                n_start   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_too_long  <= 1'b0;
            r_partial   <= '0;
            r_pos       <= '0;
            r_txt_ovf   <= 1'b0;
            r_seen      <= 1'b0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_too_long  <= n_too_long;
            r_partial   <= n_partial;
            r_pos       <= n_pos;
            r_txt_ovf   <= n_txt_ovf;
            r_seen      <= n_seen;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (pat_we) begin
            r_pat[pat_addr] <= i_item.ch;
        end
    end

endmodule

// File: dv/substring_first_match_tb.sv
// Testbench for substring_first_match: directed and random searches against a built-in predictor.
`timescale 1ns / 1ps

module substring_first_match_tb;

    localparam int   PAT_MAX       = 64;
    localparam int   POS_BITS      = 16;
    localparam int   POS_LIMIT     = (1 << POS_BITS) - 1;
    localparam int   RANDOM_CHARS  = 770;
    localparam int   CYCLE_LIMIT   = 1_000_000;
    localparam logic MODE_PATTERN  = 1'b0;
    localparam logic MODE_TEXT     = 1'b1;

    typedef logic [scm_pkg::CH_W-1:0] t_char;

    logic          clk        = 1'b0;
    logic          rst_n      = 1'b0;
    logic          in_valid   = 1'b0;
    scm_pkg::t_in  in_data    = '0;
    logic          out_ready  = 1'b0;
    logic          o_in_ready;
    logic          o_out_valid;
    scm_pkg::t_out o_out_data;

    // predictor state
    t_char                pat_bytes [PAT_MAX];
    int                   pat_len      = 0;
    bit                   pat_closed   = 1'b0;
    bit                   pat_overlong = 1'b0;
    logic [PAT_MAX-1:0]   prefix_hits  = '0;
    int                   txt_pos      = 0;
    bit                   txt_overlong = 1'b0;
    bit                   hit_seen     = 1'b0;
    int                   hit_start    = 0;

    scm_pkg::t_out expected_results [$];
    int   mismatches      = 0;
    int   results_checked = 0;
    int   chars_sent      = 0;
    int   cycle_count     = 0;
    int   stall_left      = 0;
    bit   sender_gaps     = 1'b1;
    bit   receiver_stalls = 1'b1;

    substring_first_match #(
        .PATTERN_MAX   (PAT_MAX),
        .POSITION_BITS (POS_BITS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic clear_text_state();
        prefix_hits  = '0;
        txt_pos      = 0;
        txt_overlong = 1'b0;
        hit_seen     = 1'b0;
        hit_start    = 0;
    endtask

    // Advance the search state by one accepted character; queue a result on the last text char.
    task automatic update_search(input scm_pkg::t_in item);
        scm_pkg::t_out res;
        if (item.mode == MODE_PATTERN) begin
            if (pat_closed) begin
                pat_len      = 0;
                pat_overlong = 1'b0;
                pat_closed   = 1'b0;
            end
            clear_text_state();
            if (pat_len < PAT_MAX) begin
                pat_bytes[pat_len] = item.ch;
                pat_len++;
            end else begin
                pat_overlong = 1'b1;
            end
            if (item.last)
                pat_closed = 1'b1;
        end else begin
            pat_closed = 1'b1;
            if (txt_pos >= POS_LIMIT) begin
                txt_overlong = 1'b1;
            end else begin
                for (int i = pat_len - 1; i >= 0; i--)
                    prefix_hits[i] = ((i == 0) ? 1'b1 : prefix_hits[i-1]) &&
                                     (pat_bytes[i] == item.ch);
                if (pat_len > 0 && !pat_overlong && !hit_seen && prefix_hits[pat_len-1]) begin
                    hit_seen  = 1'b1;
                    hit_start = txt_pos + 1 - pat_len;
                end
                txt_pos++;
            end
            if (item.last) begin
                res.found       = hit_seen && !pat_overlong && pat_len > 0;
                res.match_index = res.found ? hit_start[scm_pkg::IDX_W-1:0] : '0;
                res.overflow    = pat_overlong || txt_overlong;
                expected_results.push_back(res);
                clear_text_state();
            end
        end
    endtask

    task automatic send_char(input logic mode, input t_char ch, input logic fin);
        scm_pkg::t_in item;
        item.mode = mode;
        item.ch   = ch;
        item.last = fin;
        if (sender_gaps && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        update_search(item);
        chars_sent++;
    endtask

    task automatic send_string(input logic mode, input t_char chars[$]);
        foreach (chars[i])
            send_char(mode, chars[i], i == chars.size() - 1);
    endtask

    function automatic t_char rand_char();
        t_char c;
        if ($urandom_range(0, 3) == 0)
            c = t_char'($urandom_range(0, 255));
        else
            c = t_char'(8'h61 + $urandom_range(0, 2));
        return c;
    endfunction

    // receiver stalls and result checking
    always @(posedge clk) begin
        scm_pkg::t_out want;
        if (stall_left != 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_ready <= 1'b1;
        end
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with none expected: found %0d index %0d overflow %0d",
                       o_out_data.found, o_out_data.match_index, o_out_data.overflow);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_out_data.found);
                    mismatches++;
                end
                if (o_out_data.match_index !== want.match_index) begin
                    $error("match_index: expected %0d, got %0d",
                           want.match_index, o_out_data.match_index);
                    mismatches++;
                end
                if (o_out_data.overflow !== want.overflow) begin
                    $error("overflow: expected %0d, got %0d", want.overflow, o_out_data.overflow);
                    mismatches++;
                end
                results_checked++;
            end
        end
    end

    // text before any pattern was loaded
    task automatic test_no_pattern();
        send_char(MODE_TEXT, 8'h61, 1'b1);
    endtask

    // byte extremes in both pattern and text, match not at position zero
    task automatic test_basic_match();
        send_char(MODE_PATTERN, 8'h00, 1'b0);
        send_char(MODE_PATTERN, 8'hFF, 1'b1);
        send_string(MODE_TEXT, '{8'h01, 8'h00, 8'hFF, 8'h00, 8'hFF});
    endtask

    // pattern survives a result; a short text cannot hold it
    task automatic test_pattern_kept();
        send_string(MODE_TEXT, '{8'h00, 8'hFF});
        send_string(MODE_TEXT, '{8'hFF});
    endtask

    task automatic test_pattern_longer_than_text();
        send_string(MODE_PATTERN, '{8'h61, 8'h62, 8'h63});
        send_string(MODE_TEXT, '{8'h61, 8'h62});
    endtask

    // first text char closes an unterminated pattern
    task automatic test_open_pattern();
        send_char(MODE_PATTERN, 8'h78, 1'b0);
        send_char(MODE_PATTERN, 8'h79, 1'b0);
        send_string(MODE_TEXT, '{8'h78, 8'h79});
    endtask

    // pattern char in the middle of a text drops that text
    task automatic test_cut_text();
        send_char(MODE_TEXT, 8'h71, 1'b0);
        send_char(MODE_PATTERN, 8'h71, 1'b1);
        send_char(MODE_TEXT, 8'h71, 1'b1);
    endtask

    task automatic test_pattern_overflow();
        t_char pat[$];
        repeat (PAT_MAX + 1) pat.push_back(rand_char());
        send_string(MODE_PATTERN, pat);
        pat.pop_back();
        send_string(MODE_TEXT, pat);
    endtask

    task automatic test_pattern_full();
        t_char pat[$];
        t_char txt[$];
        repeat (PAT_MAX) pat.push_back(rand_char());
        send_string(MODE_PATTERN, pat);
        txt = '{8'h7E, 8'h7E, 8'h7E};
        txt = {txt, pat};
        send_string(MODE_TEXT, txt);
    endtask

    task automatic test_random();
        t_char pat[$];
        t_char txt[$];
        int    start_count;
        int    choice;
        int    plen;
        int    tlen;
        int    at;
        start_count = chars_sent;
        while (chars_sent - start_count < RANDOM_CHARS) begin
            if (chars_sent - start_count > RANDOM_CHARS * 3 / 4) begin
                sender_gaps     = 1'b0;
                receiver_stalls = 1'b0;
            end
            choice = $urandom_range(0, 9);
            if (choice == 9) begin
                // raw noise
                repeat ($urandom_range(1, 5))
                    send_char(1'($urandom_range(0, 1)), t_char'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                pat.delete();
            end else begin
                if (choice == 8) begin
                    repeat ($urandom_range(1, 5)) send_char(MODE_TEXT, rand_char(), 1'b0);
                end
                if (pat.size() == 0 || choice >= 7 || $urandom_range(0, 1) == 0) begin
                    plen = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 68)
                                                        : $urandom_range(1, 5);
                    pat.delete();
                    repeat (plen) pat.push_back(rand_char());
                    if (choice == 7) begin
                        foreach (pat[i]) send_char(MODE_PATTERN, pat[i], 1'b0);
                    end else begin
                        send_string(MODE_PATTERN, pat);
                    end
                end
                txt.delete();
                if ($urandom_range(0, 1) == 0) begin
                    tlen = pat.size() + $urandom_range(0, 20);
                    repeat (tlen) txt.push_back(rand_char());
                    at = $urandom_range(0, tlen - pat.size());
                    foreach (pat[i]) txt[at + i] = pat[i];
                end else begin
                    repeat ($urandom_range(1, 24)) txt.push_back(rand_char());
                end
                send_string(MODE_TEXT, txt);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_no_pattern();
        test_basic_match();
        test_pattern_kept();
        test_pattern_longer_than_text();
        test_open_pattern();
        test_cut_text();
        test_pattern_overflow();
        test_pattern_full();
        test_random();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Sent %0d characters and checked %0d search results,", chars_sent,
                 results_checked);
        $display("covering open, cut, full and overlong patterns and random searches.");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: substring_first_match.f
rtl/scm_pkg.sv
rtl/scm_front.sv
rtl/scm_queue.sv
rtl/scm_back.sv
rtl/substring_first_match.sv
dv/substring_first_match_tb.sv
